// ===== design/targa_rle_pixel_decoder_defines.svh =====
// assertion macros for the targa rle pixel decoder
`ifndef TARGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TARGA_RLE_PIXEL_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TRPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trpd assertion failed");

// next-cycle implication
`define TRPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trpd assertion failed");

`else

`define TRPD_ASSERT_IMP(lbl, ante, cons)
`define TRPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/trpd_pkg.sv =====
package trpd_pkg;

  localparam int CMAP_DEPTH_DEF = 16384;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 3;

  // input item kinds
  typedef enum logic [1:0] {
    ACT_CMAP  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ILACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd6;

  // pixel formats
  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;
  localparam logic [1:0] FMT_32 = 2'd3;

  // interlace modes
  localparam logic [1:0] ILACE_TWO  = 2'd1;
  localparam logic [1:0] ILACE_FOUR = 2'd2;

  localparam logic [7:0]  RUN_BIAS     = 8'd127;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
  localparam logic [15:0] MIN_WIDTH    = 16'd4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PLACE = 2'd1,
    S_OVR   = 2'd2
  } state_t;

  typedef struct packed {
    logic ovr;
    logic pix_done;
    logic col_over;
    logic close_stop;
    logic seg_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic take;
    logic close_row;
    logic emit_seg;
    logic emit_ovr;
  } dp_cmd_t;

endpackage

// ===== design/trpd_ctrl.sv =====
module trpd_ctrl import trpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (action == ACT_DATA) begin
            if (status.ovr) begin
              state_next = S_OVR;
            end else if (status.pix_done) begin
              state_next = S_PLACE;
            end
          end
        end
      end
      S_PLACE: begin
        if (status.col_over) begin
          cmd.close_row = 1'b1;
          if (status.close_stop) state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit_seg = 1'b1;
          if (status.seg_last) state_next = S_IDLE;
        end
      end
      S_OVR: begin
        if (status.out_free) begin
          cmd.emit_ovr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/trpd_datapath.sv =====
module trpd_datapath import trpd_pkg::*; #(
  parameter int CMAP_DEPTH = CMAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            action,
  input  logic [7:0]            data_byte,
  input  logic [13:0]           palette_index,
  input  logic [7:0]            palette_red,
  input  logic [7:0]            palette_green,
  input  logic [7:0]            palette_blue,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            alpha,
  output logic [15:0]           row_index,
  output logic [15:0]           start_column,
  output logic [7:0]            segment_length,
  output logic                  last_of_run,
  output logic                  image_done,
  output logic                  overread,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int AW = $clog2(CMAP_DEPTH);
  localparam logic [16:0] DEPTH_L = 17'(CMAP_DEPTH);

  // configuration registers
  logic        rle_enabled, cmap_en, origin_top;
  logic [1:0]  pixel_format, interleave_mode;
  logic [15:0] image_width, image_height;

  // decode state
  phase_t      phase;
  logic [1:0]  byte_in_pixel;
  logic [23:0] pixel_bytes;
  logic [7:0]  run_remaining;
  logic [15:0] column_pos, rows_done, interlace_row, interlace_top;

  // completed pixel waiting to be placed
  logic [7:0]  len_cnt;
  logic [31:0] pix_rgba;
  logic        pix_mapped, pix_inrange;

  // colormap
  logic [23:0] cmap [CMAP_DEPTH];
  logic [23:0] cmap_rdata;

  logic [15:0] w_eff, left, dest_row, col_add, irow_adv;
  logic [23:0] merged;
  logic [31:0] direct_rgba, seg_rgba;
  logic [15:0] map_idx, wr_ext;
  logic        pix_path, complete, map_sel, map_inrange, wr_ok, fits, reach_end;
  logic        rows1_ge, irow_wrap, data_ok;
  logic [16:0] irow_step;
  logic [2:0]  step;
  logic [7:0]  take;

  // effective width and row bookkeeping
  always_comb begin
    w_eff     = (image_width < MIN_WIDTH) ? MIN_WIDTH : image_width;
    left      = w_eff - column_pos;
    fits      = {8'h00, len_cnt} <= left;
    reach_end = {8'h00, len_cnt} >= left;
    take      = fits ? len_cnt : left[7:0];
    col_add   = column_pos + {8'h00, take};
    rows1_ge  = ({1'b0, rows_done} + 17'd1) >= {1'b0, image_height};
    if (interleave_mode == ILACE_FOUR) begin
      step = 3'd4;
    end else if (interleave_mode == ILACE_TWO) begin
      step = 3'd2;
    end else begin
      step = 3'd1;
    end
    irow_step = {1'b0, interlace_row} + {14'h0000, step};
    irow_wrap = irow_step >= {1'b0, image_height};
    irow_adv  = irow_wrap ? (interlace_top + 16'd1) : irow_step[15:0];
    dest_row  = origin_top ? interlace_row : (image_height - 16'd1 - interlace_row);
  end

  // byte merge and pixel decode
  always_comb begin
    merged = pixel_bytes;
    unique case (byte_in_pixel)
      2'd0: merged[7:0]   = data_byte;
      2'd1: merged[15:8]  = data_byte;
      2'd2: merged[23:16] = data_byte;
      2'd3: ;
    endcase
    complete = byte_in_pixel >= pixel_format;
    unique case (pixel_format)
      FMT_8:  direct_rgba = {merged[7:0], merged[7:0], merged[7:0], ALPHA_OPAQUE};
      FMT_16: direct_rgba = {3'b000, merged[14:10], 3'b000, merged[9:5],
                             3'b000, merged[4:0], ALPHA_OPAQUE};
      FMT_24: direct_rgba = {merged[23:16], merged[15:8], merged[7:0], ALPHA_OPAQUE};
      FMT_32: direct_rgba = {merged[23:16], merged[15:8], merged[7:0], data_byte};
    endcase
    map_sel     = cmap_en && !pixel_format[1];
    map_idx     = (pixel_format == FMT_8) ? {8'h00, merged[7:0]} : merged[15:0];
    map_inrange = {1'b0, map_idx} < DEPTH_L;
    wr_ext      = {2'b00, palette_index};
    wr_ok       = {3'b000, palette_index} < DEPTH_L;
    pix_path    = !rle_enabled || phase == PH_REPEAT || phase == PH_LITERAL;
    data_ok     = action == ACT_DATA && rows_done < image_height;
  end

  // segment colour
  always_comb begin
    if (pix_mapped) begin
      seg_rgba = pix_inrange ? {cmap_rdata, ALPHA_OPAQUE} : {24'h000000, ALPHA_OPAQUE};
    end else begin
      seg_rgba = pix_rgba;
    end
  end

  // status to the controller
  always_comb begin
    status.ovr        = rows_done >= image_height;
    status.pix_done   = pix_path && complete;
    status.col_over   = column_pos >= w_eff;
    status.close_stop = rows1_ge;
    status.seg_last   = fits || rows1_ge;
    status.out_free   = !out_valid || out_ready;
  end

  // colormap write and registered read
  always_ff @(posedge clk) begin
    if (cmd.take && action == ACT_CMAP && wr_ok) begin
      cmap[wr_ext[AW-1:0]] <= {palette_red, palette_green, palette_blue};
    end
    if (cmd.take) begin
      cmap_rdata <= cmap[map_idx[AW-1:0]];
    end
  end

  // configuration and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_enabled     <= 1'b1;
      pixel_format    <= FMT_24;
      cmap_en         <= 1'b0;
      origin_top      <= 1'b0;
      interleave_mode <= 2'd0;
      image_width     <= 16'd640;
      image_height    <= 16'd480;
      phase           <= PH_HEADER;
      byte_in_pixel   <= 2'd0;
      pixel_bytes     <= 24'h000000;
      run_remaining   <= 8'h00;
      column_pos      <= 16'h0000;
      rows_done       <= 16'h0000;
      interlace_row   <= 16'h0000;
      interlace_top   <= 16'h0000;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RLE:    rle_enabled     <= cfg_data[0];
          CFG_FORMAT: pixel_format    <= cfg_data[1:0];
          CFG_MAPPED: cmap_en         <= cfg_data[0];
          CFG_ORIGIN: origin_top      <= cfg_data[0];
          CFG_ILACE:  interleave_mode <= cfg_data[1:0];
          CFG_WIDTH:  image_width     <= cfg_data;
          CFG_HEIGHT: image_height    <= cfg_data;
          default: ;
        endcase
      end

      // item intake
      if (cmd.take && action == ACT_START) begin
        phase         <= PH_HEADER;
        byte_in_pixel <= 2'd0;
        pixel_bytes   <= 24'h000000;
        run_remaining <= 8'h00;
        column_pos    <= 16'h0000;
        rows_done     <= 16'h0000;
        interlace_row <= 16'h0000;
        interlace_top <= 16'h0000;
      end else if (cmd.take && data_ok) begin
        if (!pix_path) begin
          // packet header
          if (data_byte[7]) begin
            run_remaining <= data_byte - RUN_BIAS;
            phase         <= PH_REPEAT;
          end else begin
            run_remaining <= data_byte + 8'd1;
            phase         <= PH_LITERAL;
          end
          byte_in_pixel <= 2'd0;
          pixel_bytes   <= 24'h000000;
        end else if (complete) begin
          byte_in_pixel <= 2'd0;
          pixel_bytes   <= 24'h000000;
          if (rle_enabled && phase == PH_REPEAT) begin
            run_remaining <= 8'h00;
            phase         <= PH_HEADER;
          end else if (rle_enabled) begin
            run_remaining <= run_remaining - 8'd1;
            if (run_remaining == 8'd1) phase <= PH_HEADER;
          end
        end else begin
          pixel_bytes   <= merged;
          byte_in_pixel <= byte_in_pixel + 2'd1;
        end
      end

      // row advance and column update
      if (cmd.close_row || (cmd.emit_seg && reach_end)) begin
        column_pos    <= 16'h0000;
        rows_done     <= rows_done + 16'd1;
        interlace_row <= irow_adv;
        if (irow_wrap) interlace_top <= interlace_top + 16'd1;
      end else if (cmd.emit_seg) begin
        column_pos <= col_add;
      end

      // output register valid
      if (cmd.emit_seg || cmd.emit_ovr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pixel hold and output payload
  always_ff @(posedge clk) begin
    if (cmd.take && data_ok && pix_path && complete) begin
      pix_rgba    <= direct_rgba;
      pix_mapped  <= map_sel;
      pix_inrange <= map_inrange;
      len_cnt     <= (rle_enabled && phase == PH_REPEAT) ? run_remaining : 8'd1;
    end else if (cmd.emit_seg) begin
      len_cnt <= len_cnt - take;
    end
    if (cmd.emit_seg) begin
      red            <= seg_rgba[31:24];
      green          <= seg_rgba[23:16];
      blue           <= seg_rgba[15:8];
      alpha          <= seg_rgba[7:0];
      row_index      <= dest_row;
      start_column   <= column_pos;
      segment_length <= take;
      last_of_run    <= fits || rows1_ge;
      image_done     <= reach_end && rows1_ge;
      overread       <= !fits && rows1_ge;
    end else if (cmd.emit_ovr) begin
      red            <= 8'h00;
      green          <= 8'h00;
      blue           <= 8'h00;
      alpha          <= 8'h00;
      row_index      <= 16'h0000;
      start_column   <= 16'h0000;
      segment_length <= 8'h00;
      last_of_run    <= 1'b1;
      image_done     <= 1'b0;
      overread       <= 1'b1;
    end
  end

endmodule

// ===== design/targa_rle_pixel_decoder.sv =====
// Targa pixel stream decoder with optional RLE packets.
// Input channel (in_valid/in_ready): one item per handshake, either a colormap
// write, a pixel data byte or a start-of-image marker. Output channel
// (out_valid/out_ready): row segments with colour, row, start column, length.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written while the decoder is idle; the block itself does not enforce this.
// Throughput: header bytes, colormap writes, start markers and bytes that do
// not finish a pixel are taken one per cycle while the sequencer is idle. A
// byte that finishes a pixel holds the input until its segments (up to 33 for
// a 128-pixel run over narrow rows) are placed and any rows left open by a
// width change are closed; the row-split sequencer places one segment per
// cycle while the output register is free. Colormap lookups are a registered
// read, at the intake edge, of a memory with separate write and read ports.
// A byte arriving after the last row holds the input until its flag result
// is loaded; the first segment is loaded in the placement state after intake.
// Output stalls hold the sequencer while the output register is full; input
// is still taken in idle while a result waits. Reset (synchronous) restores
// the default registers and clears the decode state; colormap contents are
// undefined until written.
`include "targa_rle_pixel_decoder_defines.svh"

module targa_rle_pixel_decoder import trpd_pkg::*; #(
  parameter int CMAP_DEPTH = CMAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [7:0]            data_byte,
  input  logic [13:0]           palette_index,
  input  logic [7:0]            palette_red,
  input  logic [7:0]            palette_green,
  input  logic [7:0]            palette_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            alpha,
  output logic [15:0]           row_index,
  output logic [15:0]           start_column,
  output logic [7:0]            segment_length,
  output logic                  last_of_run,
  output logic                  image_done,
  output logic                  overread
);

  dp_status_t status;
  dp_cmd_t    cmd;

  // sequencer
  trpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  // decode and placement datapath
  trpd_datapath #(
    .CMAP_DEPTH (CMAP_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .data_byte      (data_byte),
    .palette_index  (palette_index),
    .palette_red    (palette_red),
    .palette_green  (palette_green),
    .palette_blue   (palette_blue),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .row_index      (row_index),
    .start_column   (start_column),
    .segment_length (segment_length),
    .last_of_run    (last_of_run),
    .image_done     (image_done),
    .overread       (overread),
    .cmd            (cmd),
    .status         (status)
  );

  // a finished image always ends the burst of segments
  `TRPD_ASSERT_IMP(a_done_is_last, out_valid && image_done, last_of_run)
  // a dropped tail or dropped byte is always on the final result
  `TRPD_ASSERT_IMP(a_ovr_is_last, out_valid && overread, last_of_run)
  // only the flag result for a late byte has no pixels
  `TRPD_ASSERT_IMP(a_empty_is_ovr, out_valid && segment_length == 8'h00, overread)
  // a new result is only loaded into a free output register
  `TRPD_ASSERT_NXT(a_no_overwrite, out_valid && !out_ready, $stable(row_index))

endmodule

// ===== tb/tb_checker.sv =====
`timescale 1ns / 1ps

module tb_checker import trpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [13:0] palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic [15:0] row_index,
  input  logic [15:0] start_column,
  input  logic [7:0]  segment_length,
  input  logic        last_of_run,
  input  logic        image_done,
  input  logic        overread,
  output int          fail_count,
  output int          pending_segments
);

  typedef struct packed {
    logic [7:0]  r, g, b, a;
    logic [15:0] row, col;
    logic [7:0]  len;
    logic        last, done, ovr;
  } segment_t;

  segment_t seg_q[$];

  // mirrored registers
  logic        c_rle, c_mapped, c_origin;
  logic [1:0]  c_fmt, c_ilace;
  logic [15:0] c_width, c_height;

  // mirrored decode state
  logic [23:0] cmap [CMAP_DEPTH_DEF];
  phase_t      phase;
  logic [1:0]  byte_pos;
  logic [23:0] pix_acc;
  logic [7:0]  run_left;
  logic [15:0] col_pos, rows_done, il_row, ilace_top;

  assign pending_segments = seg_q.size();

  function automatic logic [15:0] dest_row();
    if (c_origin) return il_row;
    return c_height - 16'd1 - il_row;
  endfunction

  task automatic advance_row();
    int unsigned step;
    int unsigned nr;
    step = (c_ilace == ILACE_FOUR) ? 4 : (c_ilace == ILACE_TWO) ? 2 : 1;
    rows_done = rows_done + 16'd1;
    nr = il_row + step;
    if (nr >= c_height) begin
      ilace_top = ilace_top + 16'd1;
      nr = ilace_top;
    end
    il_row = nr[15:0];
  endtask

  // split a run of one colour into row segments
  task automatic place_run(input logic [31:0] rgba, input int unsigned count,
                           inout int produced);
    int unsigned w, left, take;
    segment_t s;
    w = (c_width < 4) ? 4 : c_width;
    while (count > 0 && rows_done < c_height) begin
      if (col_pos >= w) begin
        col_pos = 0;
        advance_row();
      end else begin
        left = w - col_pos;
        take = (count < left) ? count : left;
        s = '0;
        {s.r, s.g, s.b, s.a} = rgba;
        s.row = dest_row();
        s.col = col_pos;
        s.len = take[7:0];
        col_pos = col_pos + take[15:0];
        count -= take;
        if (col_pos >= w) begin
          col_pos = 0;
          advance_row();
          if (rows_done >= c_height) s.done = 1'b1;
        end
        seg_q.push_back(s);
        produced++;
      end
    end
    if (count > 0 && produced > 0) seg_q[$].ovr = 1'b1;
  endtask

  // feed one byte into the pixel accumulator
  function automatic logic pixel_done(input logic [7:0] b, output logic [31:0] rgba);
    int unsigned need, idx;
    logic [23:0] all, e;
    logic [7:0] r, g, bl, a;
    need = c_fmt + 1;
    idx = byte_pos;
    all = pix_acc;
    a = ALPHA_OPAQUE;
    if (idx < 3) all[8*idx +: 8] = b;
    if (idx + 1 < need) begin
      pix_acc = all;
      byte_pos = 2'(idx + 1);
      return 1'b0;
    end
    byte_pos = 0;
    pix_acc = '0;
    case (c_fmt)
      FMT_8: begin
        if (c_mapped) begin
          e = cmap[all[7:0]];
          {r, g, bl} = e;
        end else begin
          r = all[7:0]; g = all[7:0]; bl = all[7:0];
        end
      end
      FMT_16: begin
        if (c_mapped) begin
          e = (all[15:0] < CMAP_DEPTH_DEF) ? cmap[all[13:0]] : 24'd0;
          {r, g, bl} = e;
        end else begin
          r = {3'd0, all[14:10]};
          g = {3'd0, all[9:5]};
          bl = {3'd0, all[4:0]};
        end
      end
      default: begin
        bl = all[7:0]; g = all[15:8]; r = all[23:16];
        if (c_fmt == FMT_32) a = b;
      end
    endcase
    rgba = {r, g, bl, a};
    return 1'b1;
  endfunction

  task automatic reset_decode();
    phase = PH_HEADER; byte_pos = 0; pix_acc = 0; run_left = 0;
    col_pos = 0; rows_done = 0; il_row = 0; ilace_top = 0;
  endtask

  // predict the segments of one accepted item
  task automatic predict_item();
    logic [31:0] rgba;
    int produced;
    segment_t s;
    produced = 0;
    case (action_t'(action))
      ACT_CMAP: cmap[palette_index] = {palette_red, palette_green, palette_blue};
      ACT_START: reset_decode();
      ACT_DATA: begin
        if (rows_done >= c_height) begin
          s = '0; s.last = 1'b1; s.ovr = 1'b1;
          seg_q.push_back(s);
          return;
        end
        if (!c_rle) begin
          if (pixel_done(data_byte, rgba)) place_run(rgba, 1, produced);
        end else if (phase == PH_HEADER) begin
          if (data_byte[7]) begin
            run_left = data_byte - RUN_BIAS;
            phase = PH_REPEAT;
          end else begin
            run_left = data_byte + 8'd1;
            phase = PH_LITERAL;
          end
          byte_pos = 0; pix_acc = 0;
        end else if (pixel_done(data_byte, rgba)) begin
          if (phase == PH_REPEAT) begin
            place_run(rgba, run_left, produced);
            run_left = 0;
            phase = PH_HEADER;
          end else begin
            place_run(rgba, 1, produced);
            run_left = run_left - 8'd1;
            if (run_left == 0) phase = PH_HEADER;
          end
        end
        if (produced > 0) seg_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    segment_t e;
    if (rst) begin
      c_rle <= 1'b1; c_fmt <= FMT_24; c_mapped <= 1'b0; c_origin <= 1'b0;
      c_ilace <= 2'd0; c_width <= 16'd640; c_height <= 16'd480;
      reset_decode();
      seg_q.delete();
      fail_count = 0;
    end else begin
      // compare the oldest expected segment
      if (out_valid && out_ready) begin
        if (seg_q.size() == 0) begin
          $error("segment with nothing expected");
          fail_count++;
        end else begin
          e = seg_q.pop_front();
          check_field("red", e.r, red);
          check_field("green", e.g, green);
          check_field("blue", e.b, blue);
          check_field("alpha", e.a, alpha);
          check_field("row_index", e.row, row_index);
          check_field("start_column", e.col, start_column);
          check_field("segment_length", e.len, segment_length);
          check_field("last_of_run", e.last, last_of_run);
          check_field("image_done", e.done, image_done);
          check_field("overread", e.ovr, overread);
        end
      end
      if (in_valid && in_ready) predict_item();
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_RLE:    c_rle <= cfg_data[0];
          CFG_FORMAT: c_fmt <= cfg_data[1:0];
          CFG_MAPPED: c_mapped <= cfg_data[0];
          CFG_ORIGIN: c_origin <= cfg_data[0];
          CFG_ILACE:  c_ilace <= cfg_data[1:0];
          CFG_WIDTH:  c_width <= cfg_data;
          CFG_HEIGHT: c_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import trpd_pkg::*; ();

  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [13:0] palette_index;
  logic [7:0]  palette_red, palette_green, palette_blue;
  logic        out_valid, out_ready;
  logic [7:0]  red, green, blue, alpha;
  logic [15:0] row_index, start_column;
  logic [7:0]  segment_length;
  logic        last_of_run, image_done, overread;
  int          fail_count, pending_segments;
  logic        calm, hold_off;
  int          quiet_cycles;
  int          items_sent;

  targa_rle_pixel_decoder DUT (.*);

  tb_checker u_checker (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // receiver: random stalls, optional long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
  end

  // watchdog on cycles without any accepted item or delivered segment
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input action_t act, input logic [7:0] b);
    logic idle;
    idle = !calm && ($urandom_range(99) < 25);
    if (idle) in_valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < 25);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    palette_index <= 14'($urandom);
    palette_red <= 8'($urandom);
    palette_green <= 8'($urandom);
    palette_blue <= 8'($urandom);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cmap_write(input logic [13:0] idx, input logic [23:0] rgb);
    in_valid <= 1'b1;
    action <= ACT_CMAP;
    data_byte <= 8'($urandom);
    palette_index <= idx;
    {palette_red, palette_green, palette_blue} <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  // wait for all segments to drain, then let the pipeline settle
  task automatic drain();
    while (pending_segments != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup(input logic rle, input logic [1:0] fmt, input logic mapped,
                       input logic org, input logic [1:0] il,
                       input logic [15:0] w, input logic [15:0] h);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_RLE, 16'(rle));
    write_reg(CFG_FORMAT, 16'(fmt));
    write_reg(CFG_MAPPED, 16'(mapped));
    write_reg(CFG_ORIGIN, 16'(org));
    write_reg(CFG_ILACE, 16'(il));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we <= 1'b0;
    send(ACT_START, 8'd0);
  endtask

  // one well-formed packet with random content
  task automatic send_packet(input int fmt_bytes, input logic [7:0] mask);
    logic [7:0] hdr;
    int npix;
    hdr = ($urandom_range(3) == 0) ? 8'(1 + $urandom_range(2)) :
          8'($urandom_range(255));
    if ($urandom_range(9) == 0) hdr = 8'hff;
    hdr = hdr & mask;
    npix = hdr[7] ? 1 : hdr + 1;
    if (npix > 6) npix = 6;
    if (!hdr[7]) hdr = 8'(npix - 1);
    send(ACT_DATA, hdr);
    for (int p = 0; p < npix; p++)
      for (int k = 0; k < fmt_bytes; k++) send(ACT_DATA, 8'($urandom) & mask);
  endtask

  // mapped 8-bit phases only use bytes in 0..31 and 128..159, all written first
  task automatic fill_palette();
    for (int i = 0; i < 32; i++) begin
      cmap_write(14'(i), 24'($urandom));
      cmap_write(14'(i + 128), 24'($urandom));
    end
  endtask

  initial begin
    int fmt, nb;
    logic mp;
    logic [7:0] mask;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; action = ACT_NONE; data_byte = '0;
    palette_index = '0; palette_red = '0; palette_green = '0; palette_blue = '0;
    calm = 1'b1; hold_off = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fill_palette();
    cmap_write(14'h3fff, 24'hffffff);

    // directed: narrow rows, full repeat run, literals, overread
    setup(1'b1, FMT_24, 1'b0, 1'b0, 2'd0, 16'd4, 16'd3);
    send(ACT_DATA, 8'hff);
    send(ACT_DATA, 8'h00); send(ACT_DATA, 8'hff); send(ACT_DATA, 8'h80);
    send(ACT_DATA, 8'h80);
    send(ACT_DATA, 8'h00); send(ACT_DATA, 8'h00); send(ACT_DATA, 8'h00);
    send(ACT_DATA, 8'h7f);
    send(ACT_NONE, 8'h55);
    setup(1'b0, FMT_32, 1'b1, 1'b1, ILACE_FOUR, 16'd2, 16'd9);
    for (int i = 0; i < 8; i++) send(ACT_DATA, 8'(i * 37));
    setup(1'b0, FMT_16, 1'b0, 1'b0, ILACE_TWO, 16'd5, 16'd1);
    send(ACT_DATA, 8'hff); send(ACT_DATA, 8'hff);
    send(ACT_DATA, 8'h00); send(ACT_DATA, 8'h00);
    setup(1'b1, FMT_8, 1'b1, 1'b0, 2'd3, 16'd65535, 16'd65535);
    send(ACT_DATA, 8'h81); send(ACT_DATA, 8'h9b);
    send(ACT_DATA, 8'h01); send(ACT_DATA, 8'h12); send(ACT_DATA, 8'h8e);

    // random phases, one fixed setting each
    calm = 1'b0;
    for (int ph = 0; items_sent < 310 || ph < 5; ph++) begin
      fmt = $urandom_range(3);
      nb = fmt + 1;
      mp = (fmt == FMT_16) ? 1'b0 : 1'($urandom);
      mask = (fmt == FMT_8 && mp) ? 8'h9f : 8'hff;
      setup(1'($urandom_range(3) != 0), fmt[1:0], mp, 1'($urandom),
            2'($urandom_range(3)), 16'($urandom_range(4, 12)),
            16'($urandom_range(1, 8)));
      if (ph == 2) calm = 1'b1;
      if (ph == 3) calm = 1'b0;
      if (ph == 4) begin
        // long receiver stall while bytes keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(9) == 0) send(ACT_DATA, 8'($urandom) & mask);
        else if ($urandom_range(19) == 0) send(ACT_NONE, 8'($urandom));
        else if ($urandom_range(19) == 0) cmap_write(14'($urandom_range(256, 16383)),
                                                     24'($urandom));
        else send_packet(nb, mask);
      end
    end

    in_valid <= 1'b0;
    drain();
    hold_off = 1'b0;
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_segments == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
